FILE: rtl/core/wos_pkg.sv
// Shared types, constants and register codes of the wavetable oscillator.
package wos_pkg;

  // Default sizes of the wave store
  localparam int unsigned TableSizeDef = 2048;
  localparam int unsigned NumWavesDef  = 4;

  // Field widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned PhaseW    = 32;
  localparam int unsigned FreqW     = 32;
  localparam int unsigned AmpW      = 16;
  localparam int unsigned GainW     = 16;
  localparam int unsigned RateW     = 36;
  localparam int unsigned WaveSelW  = 2;
  localparam int unsigned TblIndexW = 11;
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 36;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 16;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegWaveSelect  = 4'd0;
  localparam logic [CfgIndexW-1:0] RegOutputGain  = 4'd1;
  localparam logic [CfgIndexW-1:0] RegRateScale   = 4'd2;
  localparam logic [CfgIndexW-1:0] RegMaxFreq     = 4'd3;

  // Configuration reset values
  localparam logic [WaveSelW-1:0] WaveSelectRst = 2'd0;
  localparam logic [GainW-1:0]    OutputGainRst = 16'd16384;
  localparam logic [RateW-1:0]    RateScaleRst  = 36'd5864062015;
  localparam logic [FreqW-1:0]    MaxFreqRst    = 32'd1572864000;

  // Item kinds carried on tuser
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  // Configuration register set
  typedef struct packed {
    logic [WaveSelW-1:0] waveform_select;
    logic [GainW-1:0]    output_gain;
    logic [RateW-1:0]    rate_scale;
    logic [FreqW-1:0]    max_frequency;
  } cfg_t;

  // Input item payload; the first member is the most significant
  typedef struct packed {
    logic [SampleW-1:0]   table_value;
    logic [TblIndexW-1:0] table_index;
    logic [WaveSelW-1:0]  table_wave;
    logic [AmpW-1:0]      amplitude;
    logic [FreqW-1:0]     frequency;
  } in_data_t;

  localparam int unsigned InFieldsW = $bits(in_data_t);

endpackage

FILE: rtl/core/wos_cfg_regs.sv
// Configuration register file of the wavetable oscillator.
module wos_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wos_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [wos_pkg::CfgDataW-1:0]  cfg_data_i,
  output wos_pkg::cfg_t                 cfg_o
);

  wos_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index of a write transfer; drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        wos_pkg::RegWaveSelect: cfg_d.waveform_select = cfg_data_i[wos_pkg::WaveSelW-1:0];
        wos_pkg::RegOutputGain: cfg_d.output_gain     = cfg_data_i[wos_pkg::GainW-1:0];
        wos_pkg::RegRateScale:  cfg_d.rate_scale      = cfg_data_i[wos_pkg::RateW-1:0];
        wos_pkg::RegMaxFreq:    cfg_d.max_frequency   = cfg_data_i[wos_pkg::FreqW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform_select <= wos_pkg::WaveSelectRst;
      cfg_q.output_gain     <= wos_pkg::OutputGainRst;
      cfg_q.rate_scale      <= wos_pkg::RateScaleRst;
      cfg_q.max_frequency   <= wos_pkg::MaxFreqRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/wos_wave_mem.sv
// Wave store with separate write and read ports: one write and one registered read per cycle.
module wos_wave_mem #(
  parameter int unsigned DEPTH = wos_pkg::NumWavesDef * wos_pkg::TableSizeDef
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [wos_pkg::SampleW-1:0]      wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [wos_pkg::SampleW-1:0]      rdata_o
);

  logic [wos_pkg::SampleW-1:0] mem_q [DEPTH];
  logic [wos_pkg::SampleW-1:0] rdata_q;

  assign rdata_o = rdata_q;

  // Write and read; contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/wos_sample_engine.sv
// Sequencer and datapath: table writes, two-read interpolation, scaling, phase advance.
module wos_sample_engine #(
  parameter int unsigned TABLE_SIZE = wos_pkg::TableSizeDef,
  parameter int unsigned NUM_WAVES  = wos_pkg::NumWavesDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  wos_pkg::cfg_t                                cfg_i,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  wos_pkg::op_e                                 in_op_i,
  input  wos_pkg::in_data_t                            in_data_i,
  output logic                                         res_valid_o,
  input  logic                                         res_ready_i,
  output logic [wos_pkg::SampleW-1:0]                  res_data_o,
  output logic                                         mem_we_o,
  output logic [$clog2(NUM_WAVES*TABLE_SIZE)-1:0]      mem_waddr_o,
  output logic [wos_pkg::SampleW-1:0]                  mem_wdata_o,
  output logic                                         mem_re_o,
  output logic [$clog2(NUM_WAVES*TABLE_SIZE)-1:0]      mem_raddr_o,
  input  logic [wos_pkg::SampleW-1:0]                  mem_rdata_i
);

  localparam int unsigned IdxW    = $clog2(TABLE_SIZE);
  localparam int unsigned AddrW   = $clog2(NUM_WAVES * TABLE_SIZE);
  localparam int unsigned BaseW   = AddrW + 1;
  localparam int unsigned PosW    = wos_pkg::PhaseW + IdxW;
  localparam int unsigned InterpW = 33;
  localparam int unsigned AProdW  = InterpW + 17;
  localparam int unsigned TW      = 36;
  localparam int unsigned GProdW  = TW + 17;
  localparam int unsigned YW      = 24;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_INTERP,
    S_AMP,
    S_GAIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [wos_pkg::PhaseW-1:0] phase_q, phase_d;

  // Datapath registers
  logic [PosW-1:0]               pos_q, pos_d;
  logic [wos_pkg::FreqW-1:0]     freq_q, freq_d;
  logic [wos_pkg::AmpW-1:0]      amp_q, amp_d;
  logic [63:0]                   prod_lo_q, prod_lo_d;
  logic [31:0]                   prod_hi_q, prod_hi_d;
  logic [wos_pkg::SampleW-1:0]   s0_q, s0_d;
  logic signed [InterpW-1:0]     interp_q, interp_d;
  logic signed [TW-1:0]          t_q, t_d;
  logic signed [YW-1:0]          y_q, y_d;

  // Combinational helpers
  logic                          sel_ok;
  logic [wos_pkg::WaveSelW-1:0]  sel_eff;
  logic                          wr_ok;
  logic [IdxW-1:0]               idx;
  logic [IdxW-1:0]               rd_idx;
  logic [15:0]                   frac;
  logic [BaseW-1:0]              raddr_full;
  logic [BaseW-1:0]              waddr_full;
  logic signed [16:0]            diff_s;
  logic signed [16:0]            frac_s;
  logic signed [33:0]            dprod_s;
  logic signed [InterpW-1:0]     base_s;
  logic signed [16:0]            amp_s;
  logic signed [AProdW-1:0]      aprod_s;
  logic signed [16:0]            gain_s;
  logic signed [GProdW-1:0]      gprod_s;

  assign sel_ok  = 32'(cfg_i.waveform_select) < NUM_WAVES;
  assign sel_eff = sel_ok ? cfg_i.waveform_select : '0;
  assign wr_ok   = (32'(in_data_i.table_wave) < NUM_WAVES) &&
                   (32'(in_data_i.table_index) < TABLE_SIZE);
  assign idx     = pos_q[PosW-1:wos_pkg::PhaseW];
  assign frac    = pos_q[31:16];
  assign rd_idx  = (state_q == S_RD1) ? idx + IdxW'(1) : idx;

  // Table addresses: wave times table size plus entry
  assign raddr_full = BaseW'(sel_eff) * BaseW'(TABLE_SIZE) + BaseW'(rd_idx);
  assign waddr_full = BaseW'(in_data_i.table_wave) * BaseW'(TABLE_SIZE) +
                      BaseW'(in_data_i.table_index);

  assign mem_raddr_o = raddr_full[AddrW-1:0];
  assign mem_waddr_o = waddr_full[AddrW-1:0];
  assign mem_wdata_o = in_data_i.table_value;

  // Interpolation: s0*2^16 + (s1-s0)*frac
  assign diff_s  = signed'({mem_rdata_i[15], mem_rdata_i}) - signed'({s0_q[15], s0_q});
  assign frac_s  = signed'({1'b0, frac});
  assign dprod_s = diff_s * frac_s;
  assign base_s  = signed'({s0_q[15], s0_q, 16'b0});

  // Amplitude and gain products
  assign amp_s   = signed'({1'b0, amp_q});
  assign aprod_s = interp_q * amp_s;
  assign gain_s  = signed'({1'b0, cfg_i.output_gain});
  assign gprod_s = t_q * gain_s;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);

  // Saturate the result; a selector beyond the stored tables gives silence
  always_comb begin
    if (!sel_ok) begin
      res_data_o = '0;
    end else if (y_q > YW'(32767)) begin
      res_data_o = 16'h7FFF;
    end else if (y_q < -YW'(32768)) begin
      res_data_o = 16'h8000;
    end else begin
      res_data_o = y_q[15:0];
    end
  end

  // Sequence one item
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    freq_d    = freq_q;
    amp_d     = amp_q;
    prod_lo_d = prod_lo_q;
    prod_hi_d = prod_hi_q;
    s0_d      = s0_q;
    interp_d  = interp_q;
    t_d       = t_q;
    y_d       = y_q;
    mem_we_o  = 1'b0;
    mem_re_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == wos_pkg::OP_WRITE) begin
            mem_we_o = wr_ok;
          end else begin
            pos_d   = PosW'(phase_q) * PosW'(TABLE_SIZE - 1);
            freq_d  = (in_data_i.frequency < cfg_i.max_frequency) ?
                      in_data_i.frequency : cfg_i.max_frequency;
            amp_d   = in_data_i.amplitude;
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        mem_re_o  = 1'b1;
        prod_lo_d = 64'(freq_q) * 64'(cfg_i.rate_scale[31:0]);
        prod_hi_d = freq_q * 32'(cfg_i.rate_scale[35:32]);
        state_d   = S_RD1;
      end
      S_RD1: begin
        mem_re_o = 1'b1;
        s0_d     = mem_rdata_i;
        phase_d  = phase_q + prod_hi_q + prod_lo_q[63:32];
        state_d  = S_INTERP;
      end
      S_INTERP: begin
        interp_d = base_s + InterpW'(dprod_s);
        state_d  = S_AMP;
      end
      S_AMP: begin
        t_d     = TW'((aprod_s + AProdW'(8192)) >>> 14);
        state_d = S_GAIN;
      end
      S_GAIN: begin
        y_d     = YW'((gprod_s + GProdW'(536870912)) >>> 30);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state and phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    freq_q    <= freq_d;
    amp_q     <= amp_d;
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    s0_q      <= s0_d;
    interp_q  <= interp_d;
    t_q       <= t_d;
    y_q       <= y_d;
  end

endmodule

FILE: rtl/core/wavetable_oscillator_core.sv
// Wavetable oscillator with linear interpolation: top level.
//
// Input stream (s_axis_*): tuser selects the item kind. A sample item reads
// the selected table at the current phase, interpolates between two entries,
// scales by amplitude and output gain and saturates to 16 bits; it also
// advances the phase by the clamped frequency times rate_scale over 2^32. A
// write item stores one table entry and yields no output transfer.
// Output stream (m_axis_*): one 16-bit sample per sample item, in order.
// Configuration channel (cfg_*): always ready, one register per transfer;
// write it only while no item is in flight.
// Sequence: a write item is stored at the edge that takes it, and the input
// stays ready. A sample item passes from its input transfer to the output
// register through the RD0 and RD1 states, two reads of the wave store, then
// one registered step each for the interpolation, amplitude and gain
// multipliers, and the OUT state. The next item is taken only once that
// result is in the output register.
// Stalls: a result waits in the output register; while it is held and the
// next result is ready, the engine stays put and the input is not ready.
// Reset clears the phase and the output valid flag and sets the configuration
// to its reset values; table contents are undefined until written.
module wavetable_oscillator_core #(
  parameter int unsigned TABLE_SIZE = wos_pkg::TableSizeDef,
  parameter int unsigned NUM_WAVES  = wos_pkg::NumWavesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: frequency[31:0], amplitude[47:32], table_wave[49:48],
  //        table_index[60:50], table_value[76:61], zero fill
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wos_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: operation[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: sample_out[15:0]
  output logic [wos_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wos_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [wos_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned Depth = NUM_WAVES * TABLE_SIZE;
  localparam int unsigned AddrW = $clog2(Depth);

  wos_pkg::cfg_t                cfg;
  wos_pkg::in_data_t            in_data;
  wos_pkg::op_e                 in_op;
  logic                         res_valid;
  logic                         res_ready;
  logic [wos_pkg::SampleW-1:0]  res_data;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [wos_pkg::SampleW-1:0]  mem_wdata;
  logic                         mem_re;
  logic [AddrW-1:0]             mem_raddr;
  logic [wos_pkg::SampleW-1:0]  mem_rdata;
  logic                         out_valid_q, out_valid_d;
  logic [wos_pkg::OutDataW-1:0] out_data_q, out_data_d;

  assign in_data = wos_pkg::in_data_t'(s_axis_tdata[wos_pkg::InFieldsW-1:0]);
  assign in_op   = wos_pkg::op_e'(s_axis_tuser);

  wos_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wos_wave_mem #(
    .DEPTH (Depth)
  ) u_wave_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wos_sample_engine #(
    .TABLE_SIZE (TABLE_SIZE),
    .NUM_WAVES  (NUM_WAVES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (in_op),
    .in_data_i   (in_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: load when empty or when its transfer completes
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = res_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A sample item keeps the input closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (in_op == wos_pkg::OP_SAMPLE) |=> !s_axis_tready)
    else $error("input ready while a sample item is in flight");

  // A write item leaves the input ready in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (in_op == wos_pkg::OP_WRITE) |=> s_axis_tready)
    else $error("write item did not return to idle");

  // A result handed to the output register is shown next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("result lost on its way to the output register");

  // Output valid rises only from an engine result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid && res_ready))
    else $error("output valid without a result");

endmodule
